// ===== src/particle_pair_interaction_assert.svh =====
// Concurrent assertion helpers, used by the RTL queue (ppi_queue).
`ifndef PARTICLE_PAIR_INTERACTION_ASSERT_SVH
`define PARTICLE_PAIR_INTERACTION_ASSERT_SVH
`ifndef ASSERT_OFF
`define PPI_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");
`define PPI_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("assertion failed");
`else
`define PPI_ASSERT(label, clk, rst_n, prop)
`define PPI_ASSERT_NEXT(label, clk, rst_n, cond, prop)
`endif
`endif

// ===== src/ppi_pkg.sv =====
package ppi_pkg;

    localparam int FRAC_BITS_DEFAULT = 16;
    localparam int QUEUE_DEPTH       = 2;
    localparam int SUM_W             = 65;
    localparam int ROOT_W            = 33;

    typedef enum logic [1:0] {
        OP_COLLIDE = 2'd0,
        OP_ATTRACT = 2'd1,
        OP_REPEL   = 2'd2
    } t_opcode;

    typedef enum logic [1:0] {
        KIND_PASS    = 2'd0,
        KIND_ATTRACT = 2'd1,
        KIND_PUSH    = 2'd2
    } t_kind;

    typedef struct packed {
        logic        [1:0]  opcode;
        logic signed [31:0] self_x;
        logic signed [31:0] self_y;
        logic signed [31:0] self_vx;
        logic signed [31:0] self_vy;
        logic        [31:0] self_size;
        logic signed [31:0] other_x;
        logic signed [31:0] other_y;
        logic signed [31:0] other_vx;
        logic signed [31:0] other_vy;
        logic        [31:0] radius;
        logic        [31:0] damp;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] new_self_vx;
        logic signed [31:0] new_self_vy;
        logic signed [31:0] new_other_vx;
        logic signed [31:0] new_other_vy;
        logic               touched;
    } t_out_item;

    typedef struct packed {
        logic        [1:0]  op;
        logic               box;
        logic               negx;
        logic               negy;
        logic        [31:0] ax;
        logic        [31:0] ay;
        logic        [32:0] reach;
        logic        [31:0] damp;
        logic signed [31:0] svx;
        logic signed [31:0] svy;
        logic signed [31:0] ovx;
        logic signed [31:0] ovy;
    } t_front;

    typedef struct packed {
        t_kind              kind;
        logic               touched;
        logic               negx;
        logic               negy;
        logic        [31:0] ax;
        logic        [31:0] ay;
        logic        [32:0] d;
        logic        [32:0] reach;
        logic        [31:0] damp;
        logic signed [31:0] svx;
        logic signed [31:0] svy;
        logic signed [31:0] ovx;
        logic signed [31:0] ovy;
    } t_work;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

// ===== src/ppi_stream_if.sv =====
interface ppi_stream_if #(parameter type T_DATA = logic) ();
    logic  valid;
    logic  ready;
    T_DATA data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== src/particle_pair_interaction.sv =====
// Soft-sphere pair interaction kernel for 2-D particles in fixed point.
// Input channel i_in carries one particle pair per transaction (opcode,
// positions, velocities, sizes, damping); output channel o_out returns the
// updated velocities of both particles and the touched flag, one result
// per input transaction, in order.
// Throughput: one transaction per cycle while the receiver does not stall.
// The front end computes the deltas, the squares and a one-bit-per-stage
// square root; the back end spends FRAC_BITS + 1 stages on the unit-vector
// divider and FRAC_BITS + 33 stages on the damping divider, both one
// quotient bit per stage.
// A two-entry queue separates the front and back pipelines.
// Reset clears all valid flags and the queue; no item is in flight after.
// When the receiver stalls, the output register holds its transaction, the
// back end freezes, the queue fills and then i_in.ready drops.
module particle_pair_interaction #(
    parameter int FRAC_BITS = ppi_pkg::FRAC_BITS_DEFAULT
) (
    input logic          i_clk,
    input logic          i_rst_n,
    ppi_stream_if.sink   i_in,
    ppi_stream_if.source o_out
);

    logic               w_push, w_pop;
    ppi_pkg::t_work     w_front_work, w_head;
    ppi_pkg::t_q_status w_qstat;

    ppi_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in.valid),
        .i_data  (i_in.data),
        .o_ready (i_in.ready),
        .i_qstat (w_qstat),
        .o_push  (w_push),
        .o_work  (w_front_work)
    );

    ppi_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_front_work),
        .i_pop   (w_pop),
        .o_data  (w_head),
        .o_stat  (w_qstat)
    );

    ppi_back #(.FRAC_BITS(FRAC_BITS)) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_qstat (w_qstat),
        .o_pop   (w_pop),
        .i_work  (w_head),
        .o_valid (o_out.valid),
        .o_data  (o_out.data),
        .i_ready (o_out.ready)
    );

endmodule

// ===== src/ppi_div_pipe.sv =====
module ppi_div_pipe #(
    parameter int NW = 48,
    parameter int DW = 32,
    parameter int QW = 17,
    parameter int SW = 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  logic [NW-1:0] i_num_a,
    input  logic [NW-1:0] i_num_b,
    input  logic [DW-1:0] i_den,
    input  logic [SW-1:0] i_side,
    output logic          o_valid,
    output logic [QW-1:0] o_quo_a,
    output logic [QW-1:0] o_quo_b,
    output logic [SW-1:0] o_side
);

    logic          r_v     [QW];
    logic [NW-1:0] r_num_a [QW];
    logic [NW-1:0] r_num_b [QW];
    logic [DW-1:0] r_rem_a [QW];
    logic [DW-1:0] r_rem_b [QW];
    logic [QW-1:0] r_quo_a [QW];
    logic [QW-1:0] r_quo_b [QW];
    logic [DW-1:0] r_den   [QW];
    logic [SW-1:0] r_side  [QW];

    function automatic logic [DW:0] div_step(input logic [DW-1:0] rem, input logic bit_in,
                                             input logic [DW-1:0] den);
        logic [DW:0] t;
        logic [DW:0] r;
        t = {rem, bit_in};
        if (t >= {1'b0, den}) begin
            r = {1'b1, DW'(t - {1'b0, den})};
        end else begin
            r = {1'b0, t[DW-1:0]};
        end
        return r;
    endfunction

    for (genvar j = 0; j < QW; j++) begin : g_stage
        localparam int B = QW - 1 - j;
        logic          w_v;
        logic [NW-1:0] w_num_a, w_num_b;
        logic [DW-1:0] w_rem_a, w_rem_b, w_den;
        logic [QW-1:0] w_quo_a, w_quo_b;
        logic [SW-1:0] w_side;
        logic [DW:0]   w_sa, w_sb;

        if (j == 0) begin : g_first
            assign w_v     = i_valid;
            assign w_num_a = i_num_a;
            assign w_num_b = i_num_b;
            assign w_rem_a = DW'(i_num_a >> QW);
            assign w_rem_b = DW'(i_num_b >> QW);
            assign w_quo_a = '0;
            assign w_quo_b = '0;
            assign w_den   = i_den;
            assign w_side  = i_side;
        end else begin : g_next
            assign w_v     = r_v[j-1];
            assign w_num_a = r_num_a[j-1];
            assign w_num_b = r_num_b[j-1];
            assign w_rem_a = r_rem_a[j-1];
            assign w_rem_b = r_rem_b[j-1];
            assign w_quo_a = r_quo_a[j-1];
            assign w_quo_b = r_quo_b[j-1];
            assign w_den   = r_den[j-1];
            assign w_side  = r_side[j-1];
        end

        assign w_sa = div_step(w_rem_a, w_num_a[B], w_den);
        assign w_sb = div_step(w_rem_b, w_num_b[B], w_den);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[j] <= 1'b0;
            end else if (i_en) begin
                r_v[j] <= w_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_num_a[j] <= w_num_a;
                r_num_b[j] <= w_num_b;
                r_rem_a[j] <= w_sa[DW-1:0];
                r_rem_b[j] <= w_sb[DW-1:0];
                r_quo_a[j] <= w_quo_a | (QW'(w_sa[DW]) << B);
                r_quo_b[j] <= w_quo_b | (QW'(w_sb[DW]) << B);
                r_den[j]   <= w_den;
                r_side[j]  <= w_side;
            end
        end
    end

    assign o_valid = r_v[QW-1];
    assign o_quo_a = r_quo_a[QW-1];
    assign o_quo_b = r_quo_b[QW-1];
    assign o_side  = r_side[QW-1];

endmodule

// ===== src/ppi_front.sv =====
module ppi_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  ppi_pkg::t_in_item    i_data,
    output logic                 o_ready,
    input  ppi_pkg::t_q_status   i_qstat,
    output logic                 o_push,
    output ppi_pkg::t_work       o_work
);

    localparam int SUM_W  = ppi_pkg::SUM_W;
    localparam int ROOT_W = ppi_pkg::ROOT_W;
    localparam int TW     = SUM_W + 2;

    logic w_en;
    assign w_en    = !i_qstat.full;
    assign o_ready = w_en;

    logic [32:0]      w_dx, w_dy, w_adx, w_ady, w_reach;
    ppi_pkg::t_front  n_s0, r_s0, r_s1, r_s2;
    logic             r_v0, r_v1, r_v2;
    logic [63:0]      r_sqx, r_sqy;
    logic [SUM_W-1:0] r_sum;

    always_comb begin
        w_dx  = {i_data.other_x[31], i_data.other_x} - {i_data.self_x[31], i_data.self_x};
        w_dy  = {i_data.other_y[31], i_data.other_y} - {i_data.self_y[31], i_data.self_y};
        w_adx = w_dx[32] ? (~w_dx + 33'd1) : w_dx;
        w_ady = w_dy[32] ? (~w_dy + 33'd1) : w_dy;
        if (ppi_pkg::t_opcode'(i_data.opcode) == ppi_pkg::OP_COLLIDE) begin
            w_reach = {1'b0, i_data.self_size} + {1'b0, i_data.radius};
        end else begin
            w_reach = {1'b0, i_data.radius};
        end
        n_s0.op    = i_data.opcode;
        n_s0.box   = (w_adx < w_reach) && (w_ady < w_reach);
        n_s0.negx  = w_dx[32];
        n_s0.negy  = w_dy[32];
        n_s0.ax    = w_adx[31:0];
        n_s0.ay    = w_ady[31:0];
        n_s0.reach = w_reach;
        n_s0.damp  = (i_data.damp == 32'd0) ? 32'd1 : i_data.damp;
        n_s0.svx   = i_data.self_vx;
        n_s0.svy   = i_data.self_vy;
        n_s0.ovx   = i_data.other_vx;
        n_s0.ovy   = i_data.other_vy;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (w_en) begin
            r_v0 <= i_valid;
            r_v1 <= r_v0;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s0  <= n_s0;
            r_s1  <= r_s0;
            r_sqx <= r_s0.ax * r_s0.ax;
            r_sqy <= r_s0.ay * r_s0.ay;
            r_s2  <= r_s1;
            r_sum <= {1'b0, r_sqx} + {1'b0, r_sqy};
        end
    end

    ppi_pkg::t_front   r_sq_item [ROOT_W];
    logic              r_sq_v    [ROOT_W];
    logic [SUM_W-1:0]  r_sq_rem  [ROOT_W];
    logic [ROOT_W-1:0] r_sq_root [ROOT_W];

    for (genvar j = 0; j < ROOT_W; j++) begin : g_root
        localparam int B = ROOT_W - 1 - j;
        ppi_pkg::t_front   w_item;
        logic              w_v;
        logic [SUM_W-1:0]  w_rem;
        logic [ROOT_W-1:0] w_root;
        logic [TW-1:0]     w_trial, w_remx;
        logic              w_take;

        if (j == 0) begin : g_first
            assign w_item = r_s2;
            assign w_v    = r_v2;
            assign w_rem  = r_sum;
            assign w_root = '0;
        end else begin : g_next
            assign w_item = r_sq_item[j-1];
            assign w_v    = r_sq_v[j-1];
            assign w_rem  = r_sq_rem[j-1];
            assign w_root = r_sq_root[j-1];
        end

        assign w_remx  = {2'd0, w_rem};
        assign w_trial = ({{(TW-ROOT_W){1'b0}}, w_root} << (B + 1))
                       | ({{(TW-1){1'b0}}, 1'b1} << (2 * B));
        assign w_take  = w_trial <= w_remx;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sq_v[j] <= 1'b0;
            end else if (w_en) begin
                r_sq_v[j] <= w_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_sq_item[j] <= w_item;
                r_sq_rem[j]  <= w_take ? SUM_W'(w_remx - w_trial) : w_rem;
                r_sq_root[j] <= w_take ? (w_root | (ROOT_W'(1) << B)) : w_root;
            end
        end
    end

    ppi_pkg::t_front   w_last;
    logic [ROOT_W-1:0] w_d;
    logic              w_hit;

    assign w_last = r_sq_item[ROOT_W-1];
    assign w_d    = r_sq_root[ROOT_W-1];
    assign w_hit  = w_last.box && (w_d != '0) && (w_d < w_last.reach);

    always_comb begin
        o_work.touched = 1'b0;
        o_work.negx    = w_last.negx;
        o_work.negy    = w_last.negy;
        o_work.ax      = w_last.ax;
        o_work.ay      = w_last.ay;
        o_work.d       = w_d;
        o_work.reach   = w_last.reach;
        o_work.damp    = w_last.damp;
        o_work.svx     = w_last.svx;
        o_work.svy     = w_last.svy;
        o_work.ovx     = w_last.ovx;
        o_work.ovy     = w_last.ovy;
        unique case (ppi_pkg::t_opcode'(w_last.op))
            ppi_pkg::OP_COLLIDE: begin
                o_work.kind    = w_hit ? ppi_pkg::KIND_PUSH : ppi_pkg::KIND_PASS;
                o_work.touched = w_hit;
            end
            ppi_pkg::OP_ATTRACT: begin
                o_work.kind = ppi_pkg::KIND_ATTRACT;
            end
            ppi_pkg::OP_REPEL: begin
                o_work.kind = w_hit ? ppi_pkg::KIND_PUSH : ppi_pkg::KIND_PASS;
            end
            default: begin
                o_work.kind = ppi_pkg::KIND_PASS;
            end
        endcase
    end

    assign o_push = r_sq_v[ROOT_W-1] && w_en;

endmodule

// ===== src/ppi_queue.sv =====
`include "particle_pair_interaction_assert.svh"

module ppi_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  ppi_pkg::t_work     i_data,
    input  logic               i_pop,
    output ppi_pkg::t_work     o_data,
    output ppi_pkg::t_q_status o_stat
);

    localparam int DEPTH = ppi_pkg::QUEUE_DEPTH;
    localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(DEPTH + 1);

    ppi_pkg::t_work r_mem [DEPTH];
    logic [PW-1:0]  r_wptr, r_rptr;
    logic [CW-1:0]  r_count;
    logic           w_full;

    assign w_full       = r_count == CW'(DEPTH);
    assign o_stat.full  = w_full;
    assign o_stat.empty = r_count == '0;
    assign o_data       = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= (r_wptr == PW'(DEPTH - 1)) ? '0 : r_wptr + PW'(1);
            end
            if (i_pop) begin
                r_rptr <= (r_rptr == PW'(DEPTH - 1)) ? '0 : r_rptr + PW'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CW'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    `PPI_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= CW'(DEPTH))
    `PPI_ASSERT(a_no_push_full, i_clk, i_rst_n, !(i_push && w_full))
    `PPI_ASSERT_NEXT(a_count_up, i_clk, i_rst_n, i_push && !i_pop, r_count == $past(r_count) + CW'(1))

endmodule

// ===== src/ppi_back.sv =====
module ppi_back #(
    parameter int FRAC_BITS = ppi_pkg::FRAC_BITS_DEFAULT
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ppi_pkg::t_q_status i_qstat,
    output logic               o_pop,
    input  ppi_pkg::t_work     i_work,
    output logic               o_valid,
    output ppi_pkg::t_out_item o_data,
    input  logic               i_ready
);

    localparam int N1   = 32 + FRAC_BITS;
    localparam int Q1   = FRAC_BITS + 1;
    localparam int N2   = 33 + FRAC_BITS;
    localparam int PRW  = FRAC_BITS + 34;
    localparam int SIDE = $bits(ppi_pkg::t_work);

    localparam logic signed [34:0] SAT_MAX = 35'sd2147483647;
    localparam logic signed [34:0] SAT_MIN = -35'sd2147483648;

    function automatic logic [31:0] apply(input logic [31:0] v, input logic [32:0] q,
                                          input logic sub);
        logic [34:0] s;
        logic [31:0] r;
        if (sub) begin
            s = {{3{v[31]}}, v} - {2'b00, q};
        end else begin
            s = {{3{v[31]}}, v} + {2'b00, q};
        end
        if ($signed(s) > SAT_MAX) begin
            r = 32'h7FFF_FFFF;
        end else if ($signed(s) < SAT_MIN) begin
            r = 32'h8000_0000;
        end else begin
            r = s[31:0];
        end
        return r;
    endfunction

    logic w_en;
    assign w_en  = !o_valid || i_ready;
    assign o_pop = w_en && !i_qstat.empty;

    ppi_pkg::t_work r_b0;
    logic           r_b0v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b0v <= 1'b0;
        end else if (w_en) begin
            r_b0v <= !i_qstat.empty;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_b0 <= i_work;
        end
    end

    logic            w_d1_v;
    logic [Q1-1:0]   w_ux, w_uy;
    logic [SIDE-1:0] w_d1_side;
    ppi_pkg::t_work  w_d1_item;

    ppi_div_pipe #(.NW(N1), .DW(33), .QW(Q1), .SW(SIDE)) u_unit_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_b0v),
        .i_num_a ({r_b0.ax, {FRAC_BITS{1'b0}}}),
        .i_num_b ({r_b0.ay, {FRAC_BITS{1'b0}}}),
        .i_den   (r_b0.d),
        .i_side  (r_b0),
        .o_valid (w_d1_v),
        .o_quo_a (w_ux),
        .o_quo_b (w_uy),
        .o_side  (w_d1_side)
    );

    assign w_d1_item = ppi_pkg::t_work'(w_d1_side);

    ppi_pkg::t_work r_m;
    logic           r_mv;
    logic [PRW-1:0] r_prod_x, r_prod_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mv <= 1'b0;
        end else if (w_en) begin
            r_mv <= w_d1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_m      <= w_d1_item;
            r_prod_x <= w_ux * (w_d1_item.reach - w_d1_item.d);
            r_prod_y <= w_uy * (w_d1_item.reach - w_d1_item.d);
        end
    end

    logic [N2-1:0] w_num_x, w_num_y;

    always_comb begin
        if (r_m.kind == ppi_pkg::KIND_ATTRACT) begin
            w_num_x = {1'b0, r_m.ax, {FRAC_BITS{1'b0}}};
            w_num_y = {1'b0, r_m.ay, {FRAC_BITS{1'b0}}};
        end else begin
            w_num_x = {r_prod_x[FRAC_BITS+32:FRAC_BITS], {FRAC_BITS{1'b0}}};
            w_num_y = {r_prod_y[FRAC_BITS+32:FRAC_BITS], {FRAC_BITS{1'b0}}};
        end
    end

    logic            w_d2_v;
    logic [N2-1:0]   w_qx, w_qy;
    logic [SIDE-1:0] w_d2_side;
    ppi_pkg::t_work  w_f;

    ppi_div_pipe #(.NW(N2), .DW(32), .QW(N2), .SW(SIDE)) u_damp_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_mv),
        .i_num_a (w_num_x),
        .i_num_b (w_num_y),
        .i_den   (r_m.damp),
        .i_side  (r_m),
        .o_valid (w_d2_v),
        .o_quo_a (w_qx),
        .o_quo_b (w_qy),
        .o_side  (w_d2_side)
    );

    assign w_f = ppi_pkg::t_work'(w_d2_side);

    logic [32:0]        w_qcx, w_qcy;
    logic               w_app, w_subx, w_suby;
    ppi_pkg::t_out_item n_out;

    always_comb begin
        w_app  = w_f.kind != ppi_pkg::KIND_PASS;
        w_qcx  = !w_app ? 33'd0 : ((|w_qx[N2-1:33]) ? {33{1'b1}} : w_qx[32:0]);
        w_qcy  = !w_app ? 33'd0 : ((|w_qy[N2-1:33]) ? {33{1'b1}} : w_qy[32:0]);
        w_subx = (w_f.kind == ppi_pkg::KIND_PUSH) ? !w_f.negx : w_f.negx;
        w_suby = (w_f.kind == ppi_pkg::KIND_PUSH) ? !w_f.negy : w_f.negy;
        n_out.new_self_vx  = apply(w_f.svx, w_qcx, w_subx);
        n_out.new_self_vy  = apply(w_f.svy, w_qcy, w_suby);
        n_out.new_other_vx = w_f.touched ? apply(w_f.ovx, w_qcx, !w_subx) : w_f.ovx;
        n_out.new_other_vy = w_f.touched ? apply(w_f.ovy, w_qcy, !w_suby) : w_f.ovy;
        n_out.touched      = w_f.touched;
    end

    logic               r_out_v;
    ppi_pkg::t_out_item r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (w_en) begin
            r_out_v <= w_d2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_out_v;
    assign o_data  = r_out;

endmodule
